// ===== design/assert_macros.svh =====
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TRMAM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("trmam assertion failed");

// condition must never be seen outside reset
`define TRMAM_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `TRMAM_ASSERT(lbl, clk, rstn, !(cond))

`endif

// ===== design/trmam_pkg.sv =====
// shared types, codes and constants of the register/memory alu machine
`timescale 1ns / 1ps
package trmam_pkg;

  localparam int NUM_REGISTERS_DEF    = 4;
  localparam int NUM_MEMORY_WORDS_DEF = 8;

  localparam int DATA_W = 8;
  localparam int RES_W  = 17;
  localparam int IDX_W  = 4;
  localparam int IMM_W  = 16;
  localparam int ACT_W  = 4;
  localparam int ERR_W  = 3;

  localparam logic signed [RES_W-1:0] BYTE_MAX = 17'sd127;
  localparam logic signed [RES_W-1:0] BYTE_MIN = -17'sd128;

  typedef enum logic [ACT_W-1:0] {
    ACT_LDI  = 4'd0,
    ACT_READ = 4'd1,
    ACT_MOVE = 4'd2,
    ACT_ADD  = 4'd3,
    ACT_SUB  = 4'd4,
    ACT_MUL  = 4'd5,
    ACT_DIV  = 4'd6,
    ACT_MOD  = 4'd7,
    ACT_CMP  = 4'd8
  } action_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK   = 3'd0,
    ERR_LOC  = 3'd1,
    ERR_M2M  = 3'd2,
    ERR_ZERO = 3'd3,
    ERR_DIV0 = 3'd4,
    ERR_COMP = 3'd5
  } err_e;

  typedef struct packed {
    logic load;
    logic fetch;
    logic exec;
    logic div_start;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_req;
    logic div_done;
  } dp_sts_t;

endpackage

// ===== design/trmam_div.sv =====
// iterative signed 8-bit divider, one quotient bit per cycle
`timescale 1ns / 1ps
module trmam_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [trmam_pkg::DATA_W-1:0]  dividend_i,
  input  logic signed [trmam_pkg::DATA_W-1:0]  divisor_i,
  output logic                                 done_o,
  output logic signed [trmam_pkg::DATA_W:0]    quotient_o,
  output logic signed [trmam_pkg::DATA_W-1:0]  remainder_o
);
  import trmam_pkg::*;

  localparam int CntW = $clog2(DATA_W + 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [DATA_W-1:0]   quo_q, rem_q, dvs_q;
  logic                qneg_q, rneg_q;
  logic [DATA_W:0]     shifted;
  logic [DATA_W:0]     diff;
  logic                ge;
  logic [DATA_W:0]     qmag;

  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DATA_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= dividend_i[DATA_W-1] ? DATA_W'(-dividend_i) : DATA_W'(dividend_i);
      dvs_q  <= divisor_i[DATA_W-1] ? DATA_W'(-divisor_i) : DATA_W'(divisor_i);
      rem_q  <= '0;
      qneg_q <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
      rneg_q <= dividend_i[DATA_W-1];
    end else if (busy_q) begin
      rem_q <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_q <= {quo_q[DATA_W-2:0], ge};
    end
  end

  assign qmag        = {1'b0, quo_q};
  assign quotient_o  = qneg_q ? -$signed(qmag) : $signed(qmag);
  assign remainder_o = rneg_q ? -$signed(rem_q) : $signed(rem_q);
  assign done_o      = done_q;

endmodule

// ===== design/trmam_dp.sv =====
// datapath: instruction latch, register file, data memory, alu, flags and result register
`timescale 1ns / 1ps
module trmam_dp #(
  parameter int NumRegisters   = trmam_pkg::NUM_REGISTERS_DEF,
  parameter int NumMemoryWords = trmam_pkg::NUM_MEMORY_WORDS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  trmam_pkg::ctrl_cmd_t                cmd_i,
  output trmam_pkg::dp_sts_t                  sts_o,
  input  logic [trmam_pkg::ACT_W-1:0]         action_i,
  input  logic                                first_in_memory_i,
  input  logic [trmam_pkg::IDX_W-1:0]         first_index_i,
  input  logic                                second_in_memory_i,
  input  logic [trmam_pkg::IDX_W-1:0]         second_index_i,
  input  logic signed [trmam_pkg::IMM_W-1:0]  immediate_i,
  output logic signed [trmam_pkg::DATA_W-1:0] read_value_o,
  output logic                                zero_flag_o,
  output logic                                sign_flag_o,
  output logic                                overflow_flag_o,
  output logic [trmam_pkg::ERR_W-1:0]         error_code_o
);
  import trmam_pkg::*;

  localparam int RegAw = (NumRegisters > 1) ? $clog2(NumRegisters) : 1;
  localparam int MemAw = (NumMemoryWords > 1) ? $clog2(NumMemoryWords) : 1;

  // latched transaction
  logic [ACT_W-1:0]         act_q;
  logic                     fm_q, sm_q;
  logic [IDX_W-1:0]         fi_q, si_q;
  logic signed [IMM_W-1:0]  imm_q;

  // storage
  logic [DATA_W-1:0]        rf_q  [NumRegisters];
  logic [DATA_W-1:0]        mem_q [NumMemoryWords];
  logic [NumRegisters-1:0]  rf_vld_q;
  logic [NumMemoryWords-1:0] mem_vld_q;

  // operands and results
  logic signed [DATA_W-1:0] a_q, b_q;
  logic signed [RES_W-1:0]  res_q, alu_d;
  logic signed [2*DATA_W-1:0] mul;
  logic signed [DATA_W:0]   quo;
  logic signed [DATA_W-1:0] rem;
  logic                     div_done;

  logic                     zf_q, sf_q, of_q, zf_d, sf_d, of_d;
  logic signed [DATA_W-1:0] rv_q, rv_d;
  err_e                     err_q, err;

  logic f_reg_ok, f_mem_ok, s_reg_ok, s_mem_ok, f_ok, s_ok, ok;
  err_e pair_err;

  logic              wr_en, wr_mem;
  logic [IDX_W-1:0]  wr_idx;
  logic [DATA_W-1:0] wr_data;
  logic              rf_we, mem_we;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      fm_q  <= first_in_memory_i;
      fi_q  <= first_index_i;
      sm_q  <= second_in_memory_i;
      si_q  <= second_index_i;
      imm_q <= immediate_i;
    end
  end

  assign f_reg_ok = {1'b0, fi_q} < (IDX_W+1)'(NumRegisters);
  assign f_mem_ok = {1'b0, fi_q} < (IDX_W+1)'(NumMemoryWords);
  assign s_reg_ok = {1'b0, si_q} < (IDX_W+1)'(NumRegisters);
  assign s_mem_ok = {1'b0, si_q} < (IDX_W+1)'(NumMemoryWords);
  assign f_ok     = fm_q ? f_mem_ok : f_reg_ok;
  assign s_ok     = sm_q ? s_mem_ok : s_reg_ok;

  // operand fetch, unwritten entries read as zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      if (fm_q) begin
        a_q <= (f_mem_ok && mem_vld_q[fi_q[MemAw-1:0]]) ? mem_q[fi_q[MemAw-1:0]] : '0;
      end else begin
        a_q <= (f_reg_ok && rf_vld_q[fi_q[RegAw-1:0]]) ? rf_q[fi_q[RegAw-1:0]] : '0;
      end
      if (sm_q) begin
        b_q <= (s_mem_ok && mem_vld_q[si_q[MemAw-1:0]]) ? mem_q[si_q[MemAw-1:0]] : '0;
      end else begin
        b_q <= (s_reg_ok && rf_vld_q[si_q[RegAw-1:0]]) ? rf_q[si_q[RegAw-1:0]] : '0;
      end
    end
  end

  // error decode
  always_comb begin
    if (!f_ok) begin
      pair_err = ERR_LOC;
    end else if (fm_q && sm_q) begin
      pair_err = ERR_M2M;
    end else if (!s_ok) begin
      pair_err = ERR_LOC;
    end else begin
      pair_err = ERR_OK;
    end
  end

  always_comb begin
    err = ERR_OK;
    unique case (act_q) inside
      ACT_LDI: begin
        if (imm_q == '0) begin
          err = ERR_ZERO;
        end else if (!f_ok) begin
          err = ERR_LOC;
        end
      end
      ACT_READ: begin
        if (!f_ok) begin
          err = ERR_LOC;
        end
      end
      ACT_MOVE, ACT_ADD, ACT_SUB, ACT_MUL: begin
        err = pair_err;
      end
      ACT_DIV, ACT_MOD: begin
        if (pair_err != ERR_OK) begin
          err = pair_err;
        end else if (b_q == '0) begin
          err = ERR_DIV0;
        end
      end
      ACT_CMP: begin
        if (fm_q || sm_q || !f_reg_ok || !s_reg_ok) begin
          err = ERR_COMP;
        end
      end
      default: begin
        err = ERR_LOC;
      end
    endcase
  end

  assign ok = (err == ERR_OK);

  // alu
  assign mul = (2*DATA_W)'(a_q) * (2*DATA_W)'(b_q);

  always_comb begin
    unique case (act_q) inside
      ACT_ADD: alu_d = RES_W'(a_q) + RES_W'(b_q);
      ACT_SUB: alu_d = RES_W'(b_q) - RES_W'(a_q);
      ACT_MUL: alu_d = RES_W'(mul);
      default: alu_d = '0;
    endcase
  end

  trmam_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (a_q),
    .divisor_i   (b_q),
    .done_o      (div_done),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      res_q <= (act_q == ACT_DIV) ? RES_W'(quo) : RES_W'(rem);
    end else if (cmd_i.exec) begin
      res_q <= alu_d;
    end
  end

  assign sts_o.div_req  = ((act_q == ACT_DIV) || (act_q == ACT_MOD)) && ok;
  assign sts_o.div_done = div_done;

  // store write
  always_comb begin
    wr_en   = 1'b0;
    wr_mem  = 1'b0;
    wr_idx  = '0;
    wr_data = '0;
    unique case (act_q) inside
      ACT_LDI: begin
        wr_en   = ok;
        wr_mem  = fm_q;
        wr_idx  = fi_q;
        wr_data = imm_q[DATA_W-1:0];
      end
      ACT_MOVE: begin
        wr_en   = ok;
        wr_mem  = sm_q;
        wr_idx  = si_q;
        wr_data = a_q;
      end
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD: begin
        wr_en   = ok;
        wr_data = res_q[DATA_W-1:0];
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign rf_we  = cmd_i.commit && wr_en && !wr_mem;
  assign mem_we = cmd_i.commit && wr_en && wr_mem;

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_q[wr_idx[RegAw-1:0]] <= wr_data;
    end
    if (mem_we) begin
      mem_q[wr_idx[MemAw-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q  <= '0;
      mem_vld_q <= '0;
    end else begin
      if (rf_we) begin
        rf_vld_q[wr_idx[RegAw-1:0]] <= 1'b1;
      end
      if (mem_we) begin
        mem_vld_q[wr_idx[MemAw-1:0]] <= 1'b1;
      end
    end
  end

  // flags and read value
  always_comb begin
    zf_d = zf_q;
    sf_d = sf_q;
    of_d = of_q;
    unique case (act_q) inside
      ACT_LDI: begin
        zf_d = 1'b0;
        sf_d = ok && imm_q[IMM_W-1];
        of_d = ok && ((imm_q > IMM_W'(BYTE_MAX)) || (imm_q < IMM_W'(BYTE_MIN)));
      end
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD: begin
        zf_d = ok && (res_q == '0);
        sf_d = ok && res_q[RES_W-1];
        of_d = ok && ((res_q > BYTE_MAX) || (res_q < BYTE_MIN));
      end
      ACT_CMP: begin
        zf_d = ok && (a_q == b_q);
        sf_d = ok && (a_q > b_q);
        of_d = 1'b0;
      end
      default: begin
        zf_d = zf_q;
      end
    endcase
  end

  assign rv_d = ((act_q == ACT_READ) && ok) ? a_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zf_q <= 1'b0;
      sf_q <= 1'b0;
      of_q <= 1'b0;
    end else if (cmd_i.commit) begin
      zf_q <= zf_d;
      sf_q <= sf_d;
      of_q <= of_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rv_q  <= rv_d;
      err_q <= err;
    end
  end

  assign read_value_o    = rv_q;
  assign zero_flag_o     = zf_q;
  assign sign_flag_o     = sf_q;
  assign overflow_flag_o = of_q;
  assign error_code_o    = err_q;

endmodule

// ===== design/trmam_ctrl.sv =====
// controller state machine and output valid register
`timescale 1ns / 1ps
module trmam_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output trmam_pkg::ctrl_cmd_t  cmd_o,
  input  trmam_pkg::dp_sts_t    sts_i
);
  import trmam_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_EXEC  = 5'b00100,
    S_DIV   = 5'b01000,
    S_WB    = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   commit;

  assign in_ready_o = (state_q == S_IDLE);
  assign commit     = (state_q == S_WB) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = sts_i.div_req ? S_DIV : S_WB;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = commit || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o.load      = in_valid_i && in_ready_o;
  assign cmd_o.fetch     = (state_q == S_FETCH);
  assign cmd_o.exec      = (state_q == S_EXEC);
  assign cmd_o.div_start = (state_q == S_EXEC) && sts_i.div_req;
  assign cmd_o.commit    = commit;
  assign out_valid_o     = out_valid_q;

endmodule

// ===== design/tiny_register_memory_alu_machine.sv =====
// top level of the register/memory alu machine
`timescale 1ns / 1ps
// One decoded instruction per input transaction, one result transaction per
// instruction. Instructions run one at a time through fetch, execute and
// writeback; div and mod add a divide state in which the 8-step
// shift-subtract divider produces one quotient bit per cycle. A new
// instruction is accepted the cycle after the previous one has moved into the
// output register, even if that result is not yet taken; writeback stalls
// only while the output register is still full. Registers, memory bytes and
// flags read as zero after reset; no clearing pass is run.
module tiny_register_memory_alu_machine #(
  parameter int NumRegisters   = trmam_pkg::NUM_REGISTERS_DEF,
  parameter int NumMemoryWords = trmam_pkg::NUM_MEMORY_WORDS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [trmam_pkg::ACT_W-1:0]         action_i,
  input  logic                                first_in_memory_i,
  input  logic [trmam_pkg::IDX_W-1:0]         first_index_i,
  input  logic                                second_in_memory_i,
  input  logic [trmam_pkg::IDX_W-1:0]         second_index_i,
  input  logic signed [trmam_pkg::IMM_W-1:0]  immediate_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [trmam_pkg::DATA_W-1:0] read_value_o,
  output logic                                zero_flag_o,
  output logic                                sign_flag_o,
  output logic                                overflow_flag_o,
  output logic [trmam_pkg::ERR_W-1:0]         error_code_o
);
  import trmam_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  trmam_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  trmam_dp #(
    .NumRegisters   (NumRegisters),
    .NumMemoryWords (NumMemoryWords)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .action_i           (action_i),
    .first_in_memory_i  (first_in_memory_i),
    .first_index_i      (first_index_i),
    .second_in_memory_i (second_in_memory_i),
    .second_index_i     (second_index_i),
    .immediate_i        (immediate_i),
    .read_value_o       (read_value_o),
    .zero_flag_o        (zero_flag_o),
    .sign_flag_o        (sign_flag_o),
    .overflow_flag_o    (overflow_flag_o),
    .error_code_o       (error_code_o)
  );

endmodule

// ===== design/trmam_chk.sv =====
// port-level checker for the register/memory alu machine and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module trmam_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic [trmam_pkg::ACT_W-1:0]         action_i,
  input logic                                first_in_memory_i,
  input logic [trmam_pkg::IDX_W-1:0]         first_index_i,
  input logic                                second_in_memory_i,
  input logic [trmam_pkg::IDX_W-1:0]         second_index_i,
  input logic signed [trmam_pkg::IMM_W-1:0]  immediate_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [trmam_pkg::DATA_W-1:0] read_value_o,
  input logic                                zero_flag_o,
  input logic                                sign_flag_o,
  input logic                                overflow_flag_o,
  input logic [trmam_pkg::ERR_W-1:0]         error_code_o
);
  import trmam_pkg::*;

  // stalled result holds
  `TRMAM_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o) && $stable(error_code_o) && $stable(zero_flag_o) && $stable(sign_flag_o) && $stable(overflow_flag_o))

  // one transaction in flight: no acceptance right after an acceptance
  `TRMAM_ASSERT(a_one_inflight, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)

  // a nonzero read value only comes from a successful read
  `TRMAM_ASSERT(a_read_ok, clk_i, rst_ni, out_valid_o && (read_value_o != '0) |-> error_code_o == ERR_OK)

  // errors of flag-clearing instructions leave the flags cleared
  `TRMAM_ASSERT(a_err_flags, clk_i, rst_ni, out_valid_o && (error_code_o == ERR_ZERO || error_code_o == ERR_DIV0 || error_code_o == ERR_COMP) |-> !zero_flag_o && !sign_flag_o && !overflow_flag_o)

  // zero and sign are exclusive
  `TRMAM_ASSERT_NEVER(a_zs_excl, clk_i, rst_ni, zero_flag_o && sign_flag_o)

endmodule

bind tiny_register_memory_alu_machine trmam_chk u_trmam_chk (.*);
